[rtl/core/salc_pkg.sv]
// Shared types and constants of the set-associative LRU cache lookup.
// Used by every module under rtl/core but salc_ram; depends on nothing.
`default_nettype none

package salc_pkg;

    // Geometry
    localparam int MAX_SETS   = 1024;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 32;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int NWAYS_W    = WAY_W + 1;
    localparam int FILL_W     = 4;
    localparam int TAG_ROWS   = MAX_SETS * MAX_WAYS;

    // Configuration register widths and indexes
    localparam int OFF_W   = 5;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 5;
    localparam int CFG_A_W = 2;

    localparam logic [CFG_A_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_WAYS        = 2'd2;

    localparam logic [OFF_W-1:0] RST_OFFSET_BITS = 5'd4;
    localparam logic [IDX_W-1:0] RST_INDEX_BITS  = 4'd6;
    localparam logic [IDX_W-1:0] RST_WAYS        = 4'd1;

    // Result codes
    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CAPACITY   = 2'd2
    } t_outcome;

    // Per-set bookkeeping row: recency list (LRU first), fill count, valid bits
    typedef struct packed {
        logic [MAX_WAYS-1:0][WAY_W-1:0] order;
        logic [FILL_W-1:0]              fill;
        logic [MAX_WAYS-1:0]            valid;
    } t_meta;

    // Address split result
    typedef struct packed {
        logic [ADDR_WIDTH-1:0] tag;
        logic [SET_W-1:0]      set;
    } t_split;

endpackage

`default_nettype wire

[rtl/core/set_assoc_lru_cache_lookup.sv]
// Set-associative cache lookup with LRU replacement: top level and sequencer.
// Depends on salc_pkg, salc_ram, salc_addr_split and salc_lru_update.
//
// One address per transaction; each yields one result (hit, compulsory miss or
// capacity miss, the way used, and saturating hit and access totals). After
// reset a clearing pass writes the 1024 per-set bookkeeping rows, one a cycle,
// so no address is taken until the pass is over; configuration writes are
// taken at any time. A new address is taken only once the previous lookup is
// through, its search having stopped at some way w (0 to 7): the tags of a
// set are read from one tag RAM port and checked by a single comparator, one
// way a cycle, then the set's row is written back once the result register is
// free. The result sits in an output register, so a stalled result does not hold
// off the next address until that result is needed again.
`default_nettype none

module set_assoc_lru_cache_lookup (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [salc_pkg::CFG_A_W-1:0]      i_cfg_index,
    input  wire logic [salc_pkg::CFG_W-1:0]        i_cfg_data,
    // address channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [salc_pkg::ADDR_WIDTH-1:0]   i_address,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [1:0]                        o_outcome,
    output logic      [salc_pkg::WAY_W-1:0]        o_way_used,
    output logic      [31:0]                       o_hit_total,
    output logic      [31:0]                       o_access_total
);

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    localparam int META_W = $bits(salc_pkg::t_meta);
    localparam int TAG_A_W = salc_pkg::SET_W + salc_pkg::WAY_W;

    t_state                             r_state;
    logic [salc_pkg::SET_W-1:0]         r_clr_addr;
    logic [salc_pkg::OFF_W-1:0]         r_offset_bits;
    logic [salc_pkg::IDX_W-1:0]         r_index_bits;
    logic [salc_pkg::IDX_W-1:0]         r_ways;
    logic [salc_pkg::SET_W-1:0]         r_set;
    logic [salc_pkg::ADDR_WIDTH-1:0]    r_tag;
    logic [salc_pkg::WAY_W-1:0]         r_way;
    logic [salc_pkg::NWAYS_W-1:0]       r_nways;
    salc_pkg::t_outcome                 r_outcome;
    logic [salc_pkg::WAY_W-1:0]         r_way_used;
    logic [31:0]                        r_hit_cnt;
    logic [31:0]                        r_acc_cnt;
    logic                               r_out_valid;
    salc_pkg::t_outcome                 r_out_outcome;
    logic [salc_pkg::WAY_W-1:0]         r_out_way;
    logic [31:0]                        r_out_hit;
    logic [31:0]                        r_out_acc;

    logic [31:0]                        n_hit_cnt;
    logic [31:0]                        n_acc_cnt;
    logic                               n_out_valid;

    salc_pkg::t_split                   split;
    logic [salc_pkg::NWAYS_W-1:0]       nways;
    logic                               accept;
    logic                               out_free;

    logic                               meta_we;
    logic [salc_pkg::SET_W-1:0]         meta_waddr;
    logic [META_W-1:0]                  meta_wdata;
    logic [META_W-1:0]                  meta_rdata;
    salc_pkg::t_meta                    meta_cur;
    salc_pkg::t_meta                    meta_new;

    logic                               tag_we;
    logic [TAG_A_W-1:0]                 tag_waddr;
    logic                               tag_re;
    logic [TAG_A_W-1:0]                 tag_raddr;
    logic [salc_pkg::ADDR_WIDTH-1:0]    tag_rdata;

    logic                               way_valid;
    logic                               way_match;
    logic                               way_last;
    logic                               cmp_hit;
    logic                               cmp_comp;
    logic                               cmp_cap;
    logic                               cmp_next;

    // Handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Associativity in use, clamped to 1..MAX_WAYS
    always_comb begin
        if (r_ways == '0) begin
            nways = salc_pkg::NWAYS_W'(1);
        end else if (r_ways > salc_pkg::IDX_W'(salc_pkg::MAX_WAYS)) begin
            nways = salc_pkg::NWAYS_W'(salc_pkg::MAX_WAYS);
        end else begin
            nways = salc_pkg::NWAYS_W'(r_ways);
        end
    end

    salc_addr_split u_split (
        .i_address     (i_address),
        .i_offset_bits (r_offset_bits),
        .i_index_bits  (r_index_bits),
        .o_split       (split)
    );

    // Shared way comparator
    assign meta_cur  = salc_pkg::t_meta'(meta_rdata);
    assign way_valid = meta_cur.valid[r_way];
    assign way_match = (tag_rdata == r_tag);
    assign way_last  = ({1'b0, r_way} == (r_nways - salc_pkg::NWAYS_W'(1)));
    assign cmp_hit   = (r_state == S_CMP) && way_valid && way_match;
    assign cmp_comp  = (r_state == S_CMP) && !way_valid;
    assign cmp_cap   = (r_state == S_CMP) && way_valid && !way_match && way_last;
    assign cmp_next  = (r_state == S_CMP) && way_valid && !way_match && !way_last;

    // Tag RAM: first way read on accept, next way while searching, fill on miss
    always_comb begin
        tag_re    = accept || cmp_next;
        tag_raddr = accept ? {split.set, salc_pkg::WAY_W'(0)}
                           : {r_set, r_way + salc_pkg::WAY_W'(1)};
        tag_we    = cmp_comp || cmp_cap;
        tag_waddr = cmp_cap ? {r_set, meta_cur.order[0]} : {r_set, r_way};
    end

    salc_ram #(
        .WIDTH (salc_pkg::ADDR_WIDTH),
        .DEPTH (salc_pkg::TAG_ROWS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_tag),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    salc_lru_update u_lru (
        .i_meta  (meta_cur),
        .i_way   (r_way_used),
        .i_nways (r_nways),
        .o_meta  (meta_new)
    );

    // Bookkeeping RAM: cleared after reset, written back once per lookup
    always_comb begin
        meta_we    = (r_state == S_CLR) || ((r_state == S_UPD) && out_free);
        meta_waddr = (r_state == S_CLR) ? r_clr_addr : r_set;
        meta_wdata = (r_state == S_CLR) ? '0 : META_W'(meta_new);
    end

    salc_ram #(
        .WIDTH (META_W),
        .DEPTH (salc_pkg::MAX_SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (accept),
        .i_raddr (split.set),
        .o_rdata (meta_rdata)
    );

    // Saturating totals
    always_comb begin
        n_hit_cnt = r_hit_cnt;
        if ((r_outcome == salc_pkg::OUT_HIT) && (r_hit_cnt != '1)) begin
            n_hit_cnt = r_hit_cnt + 32'd1;
        end
        n_acc_cnt = r_acc_cnt;
        if (r_acc_cnt != '1) begin
            n_acc_cnt = r_acc_cnt + 32'd1;
        end
    end

    // Result register occupancy: drained when the result is taken, loaded at write-back
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if ((r_state == S_UPD) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= salc_pkg::RST_OFFSET_BITS;
            r_index_bits  <= salc_pkg::RST_INDEX_BITS;
            r_ways        <= salc_pkg::RST_WAYS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                salc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                salc_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[salc_pkg::IDX_W-1:0];
                salc_pkg::CFG_WAYS:        r_ways        <= i_cfg_data[salc_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, totals and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_hit_cnt   <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + salc_pkg::SET_W'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_set   <= split.set;
                        r_tag   <= split.tag;
                        r_way   <= '0;
                        r_nways <= nways;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (cmp_hit) begin
                        r_outcome  <= salc_pkg::OUT_HIT;
                        r_way_used <= r_way;
                        r_state    <= S_UPD;
                    end else if (cmp_comp) begin
                        r_outcome  <= salc_pkg::OUT_COMPULSORY;
                        r_way_used <= r_way;
                        r_state    <= S_UPD;
                    end else if (cmp_cap) begin
                        r_outcome  <= salc_pkg::OUT_CAPACITY;
                        r_way_used <= meta_cur.order[0];
                        r_state    <= S_UPD;
                    end else begin
                        r_way <= r_way + salc_pkg::WAY_W'(1);
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        r_hit_cnt     <= n_hit_cnt;
                        r_acc_cnt     <= n_acc_cnt;
                        r_out_outcome <= r_outcome;
                        r_out_way     <= r_way_used;
                        r_out_hit     <= n_hit_cnt;
                        r_out_acc     <= n_acc_cnt;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_out_outcome;
    assign o_way_used     = r_out_way;
    assign o_hit_total    = r_out_hit;
    assign o_access_total = r_out_acc;

endmodule

`default_nettype wire

[rtl/core/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; read data holds while no read is issued.
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/salc_addr_split.sv]
// Splits an access address into tag and set index under the configured widths.
// Depends on salc_pkg.
`default_nettype none

module salc_addr_split (
    input  wire logic [salc_pkg::ADDR_WIDTH-1:0] i_address,
    input  wire logic [salc_pkg::OFF_W-1:0]      i_offset_bits,
    input  wire logic [salc_pkg::IDX_W-1:0]      i_index_bits,
    output salc_pkg::t_split                     o_split
);

    logic [salc_pkg::OFF_W:0]          shift;
    logic [salc_pkg::ADDR_WIDTH-1:0]   above;
    logic [salc_pkg::ADDR_WIDTH-1:0]   mask;

    // Tag is zero once offset plus index covers the whole address
    assign shift = {1'b0, i_offset_bits} + {2'b00, i_index_bits};

    assign o_split.tag = (shift < (salc_pkg::OFF_W + 1)'(salc_pkg::ADDR_WIDTH))
                         ? (i_address >> shift) : '0;

    // Set index: bits above the offset, masked, folded onto the set count
    assign above       = i_address >> i_offset_bits;
    assign mask        = (salc_pkg::ADDR_WIDTH'(1) << i_index_bits)
                         - salc_pkg::ADDR_WIDTH'(1);
    assign o_split.set = above[salc_pkg::SET_W-1:0] & mask[salc_pkg::SET_W-1:0];

endmodule

`default_nettype wire

[rtl/core/salc_lru_update.sv]
// Recency list update for one set: moves the used way to most recent,
// appends it while the list is short, and marks the way valid.
// Depends on salc_pkg.
`default_nettype none

module salc_lru_update (
    input  salc_pkg::t_meta                      i_meta,
    input  wire logic [salc_pkg::WAY_W-1:0]      i_way,
    input  wire logic [salc_pkg::NWAYS_W-1:0]    i_nways,
    output salc_pkg::t_meta                      o_meta
);

    logic [salc_pkg::MAX_WAYS-1:0] app;
    logic [salc_pkg::MAX_WAYS-1:0] hit;
    logic                          found;
    logic                          append;
    logic [salc_pkg::WAY_W-1:0]    pos;
    logic [salc_pkg::FILL_W-1:0]   last;
    logic [salc_pkg::FILL_W-1:0]   nw_m1;
    logic [salc_pkg::FILL_W-1:0]   fill_m1;

    // Per-slot tests: free slot within the list, or slot holding this way
    always_comb begin
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
            app[i] = (salc_pkg::NWAYS_W'(i) < i_nways) &&
                     (salc_pkg::FILL_W'(i) >= i_meta.fill);
            hit[i] = (salc_pkg::NWAYS_W'(i) < i_nways) &&
                     (salc_pkg::FILL_W'(i) < i_meta.fill) &&
                     (i_meta.order[i] == i_way);
        end
    end

    // First slot that decides the update
    always_comb begin
        found  = 1'b0;
        append = 1'b0;
        pos    = '0;
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
            if (!found && (app[i] || hit[i])) begin
                found  = 1'b1;
                append = app[i];
                pos    = salc_pkg::WAY_W'(i);
            end
        end
    end

    // Last occupied slot that a move may reach
    assign nw_m1   = salc_pkg::FILL_W'(i_nways) - salc_pkg::FILL_W'(1);
    assign fill_m1 = i_meta.fill - salc_pkg::FILL_W'(1);
    assign last    = (nw_m1 < fill_m1) ? nw_m1 : fill_m1;

    always_comb begin
        o_meta        = i_meta;
        o_meta.valid  = i_meta.valid | (salc_pkg::MAX_WAYS'(1) << i_way);
        if (found && append) begin
            o_meta.order[pos] = i_way;
            o_meta.fill       = salc_pkg::FILL_W'(pos) + salc_pkg::FILL_W'(1);
        end else if (found) begin
            // Shift the younger entries down and put this way at the end
            for (int j = 0; j < salc_pkg::MAX_WAYS - 1; j++) begin
                if ((salc_pkg::WAY_W'(j) >= pos) && (salc_pkg::FILL_W'(j) < last)) begin
                    o_meta.order[j] = i_meta.order[j + 1];
                end
            end
            for (int j = 0; j < salc_pkg::MAX_WAYS; j++) begin
                if (salc_pkg::FILL_W'(j) == last) begin
                    o_meta.order[j] = i_way;
                end
            end
        end
    end

endmodule

`default_nettype wire

[test/set_assoc_lru_cache_lookup_tb.sv]
// Testbench for the set-associative LRU cache lookup: directed and random address traffic
// over many register settings, checked result by result against a cache model held here.
// Depends on salc_pkg and the set_assoc_lru_cache_lookup RTL; needs no other file.

// Cache model and store of expected lookup results
class lookup_scoreboard;
    typedef struct {
        salc_pkg::t_outcome outcome;
        bit [2:0]           way;
        bit [31:0]          hits;
        bit [31:0]          accesses;
    } lookup_result_t;

    // register copies, reset values
    bit [4:0]  offset_bits = salc_pkg::RST_OFFSET_BITS;
    bit [3:0]  index_bits  = salc_pkg::RST_INDEX_BITS;
    bit [3:0]  ways_reg    = salc_pkg::RST_WAYS;

    // cache state
    bit [31:0] tag_row    [salc_pkg::TAG_ROWS];
    bit        valid_row  [salc_pkg::TAG_ROWS];
    bit [2:0]  recency    [salc_pkg::MAX_SETS][salc_pkg::MAX_WAYS];
    bit [3:0]  fill_count [salc_pkg::MAX_SETS];
    bit [31:0] hit_total;
    bit [31:0] access_total;

    lookup_result_t pending_lookups[$];
    int errors;
    int checked;
    int outcome_count[3];

    function void write_reg(bit [1:0] idx, bit [4:0] data);
        case (idx)
            salc_pkg::CFG_OFFSET_BITS: offset_bits = data;
            salc_pkg::CFG_INDEX_BITS:  index_bits  = data[3:0];
            salc_pkg::CFG_WAYS:        ways_reg    = data[3:0];
            default: ;
        endcase
    endfunction

    // Move a way to the most recently used end of its set's list
    function void promote_way(int set_no, int way, int nw);
        int f;
        int i;
        int j;
        int last;
        f = fill_count[set_no];
        for (i = 0; i < nw; i++) begin
            if (i >= f) begin
                recency[set_no][i] = way;
                fill_count[set_no] = i + 1;
                return;
            end
            if (recency[set_no][i] == way) begin
                if (i == nw - 1 || i + 1 >= f)
                    return;
                last = i;
                for (j = i; j < nw - 1 && j + 1 < f; j++) begin
                    recency[set_no][j] = recency[set_no][j + 1];
                    last = j + 1;
                end
                recency[set_no][last] = way;
                return;
            end
        end
    endfunction

    // Accepted address: look it up, update the cache and queue the expected result
    function void note_address(bit [31:0] addr);
        int             nw;
        int             shift;
        int             set_no;
        int             base;
        int             i;
        bit [31:0]      tag;
        bit [31:0]      above;
        bit [31:0]      mask;
        lookup_result_t res;
        nw = (ways_reg == 0) ? 1 : (ways_reg > salc_pkg::MAX_WAYS) ? salc_pkg::MAX_WAYS
                                                                   : ways_reg;
        shift = offset_bits + index_bits;
        tag = (shift < 32) ? (addr >> shift) : 32'd0;
        above = addr >> offset_bits;
        mask = (32'd1 << index_bits) - 32'd1;
        set_no = (above & mask) % salc_pkg::MAX_SETS;
        base = set_no * salc_pkg::MAX_WAYS;
        res.outcome = salc_pkg::OUT_HIT;
        res.way = 0;
        for (i = 0; i < nw; i++) begin
            if (valid_row[base + i] && tag_row[base + i] == tag) begin
                res.outcome = salc_pkg::OUT_HIT;
                res.way = i;
                break;
            end
            if (!valid_row[base + i]) begin
                res.outcome = salc_pkg::OUT_COMPULSORY;
                res.way = i;
                tag_row[base + i] = tag;
                valid_row[base + i] = 1'b1;
                break;
            end
            // set full: evict the head of the list, whatever way it names
            if (i == nw - 1) begin
                res.outcome = salc_pkg::OUT_CAPACITY;
                res.way = recency[set_no][0];
                tag_row[base + res.way] = tag;
                valid_row[base + res.way] = 1'b1;
            end
        end
        promote_way(set_no, res.way, nw);
        if (res.outcome == salc_pkg::OUT_HIT && hit_total != 32'hFFFF_FFFF)
            hit_total++;
        if (access_total != 32'hFFFF_FFFF)
            access_total++;
        res.hits = hit_total;
        res.accesses = access_total;
        outcome_count[res.outcome]++;
        pending_lookups.push_back(res);
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(logic [1:0] outcome, logic [2:0] way,
                               logic [31:0] hits, logic [31:0] accesses);
        lookup_result_t exp_res;
        checked++;
        if (pending_lookups.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result %0d arrived with nothing outstanding", checked);
            return;
        end
        exp_res = pending_lookups.pop_front();
        if (outcome !== exp_res.outcome || way !== exp_res.way ||
            hits !== exp_res.hits || accesses !== exp_res.accesses) begin
            errors++;
            if (errors <= 10)
                $display("result %0d: expected outcome %0d way %0d hits %0d accesses %0d, %s %0d %0d %0d %0d",
                         checked, exp_res.outcome, exp_res.way, exp_res.hits,
                         exp_res.accesses, "got", outcome, way, hits, accesses);
        end
    endfunction
endclass

module set_assoc_lru_cache_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [salc_pkg::CFG_A_W-1:0] CFG_SPARE = 2'd3;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 108;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_outcome;
    logic [2:0]  o_way_used;
    logic [31:0] o_hit_total;
    logic [31:0] o_access_total;

    lookup_scoreboard sb = new();

    // idling controls shared with the result side
    bit no_idle = 1'b0;
    int hold_cycles = 0;

    // directed run: offset 4, index 2, two ways; set = addr[5:4], tag = addr[31:6]
    bit [31:0] directed_addr [0:13] = '{
        32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'h0000_0040,
        32'h0000_0000, 32'h0000_0080, 32'h0000_0040, 32'h0000_0080,
        32'hFFFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h0000_0000
    };

    // register settings per random phase, as written (ways/index above 15 are masked)
    bit [4:0] phase_off  [0:N_PHASES-1] = '{0, 31, 4, 6, 2, 5, 16, 20, 3, 8, 1, 10};
    bit [4:0] phase_idx  [0:N_PHASES-1] = '{0, 15, 6, 3, 12, 10, 10, 12, 4, 8, 17, 5};
    bit [4:0] phase_ways [0:N_PHASES-1] = '{1, 15, 4, 3, 8, 0, 5, 6, 7, 9, 18, 8};

    set_assoc_lru_cache_lookup u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_outcome      (o_outcome),
        .o_way_used     (o_way_used),
        .o_hit_total    (o_hit_total),
        .o_access_total (o_access_total)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: register writes and both channels' transactions, pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_outcome, o_way_used, o_hit_total, o_access_total);
            if (i_in_valid && !o_in_stall)
                sb.note_address(i_address);
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // Address built from tag, set and random low bits under a given split
    function automatic bit [31:0] form_address(bit [31:0] tag, bit [31:0] set_no,
                                               bit [4:0] off, bit [3:0] idx);
        bit [63:0] a;
        int        sh;
        sh = off + idx;
        a = ({32'd0, tag} << sh)
          | ({32'd0, set_no & ((32'd1 << idx) - 32'd1)} << off)
          | ({32'd0, $urandom} & ((64'd1 << off) - 64'd1));
        return a[31:0];
    endfunction

    // Write all registers back to back, the spare index included
    task automatic program_cache(bit [4:0] off, bit [4:0] idx, bit [4:0] nways);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= salc_pkg::CFG_OFFSET_BITS;
        i_cfg_data  <= off;
        @(posedge i_clk);
        i_cfg_index <= salc_pkg::CFG_INDEX_BITS;
        i_cfg_data  <= idx;
        @(posedge i_clk);
        i_cfg_index <= salc_pkg::CFG_WAYS;
        i_cfg_data  <= nways;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= $urandom_range(0, 31);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One address transaction; returns at the edge that accepts it
    task automatic send_address(bit [31:0] addr);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Wait for every outstanding result, then let the write-back finish
    task automatic drain_lookups();
        while (sb.pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Result side: random stall before each transaction, or a long hold when asked
    initial begin
        int n;
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = draw_gap();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Stimulus
    initial begin
        bit [31:0] tag_pool [$];
        bit [31:0] set_pool [$];
        int        p;
        int        k;
        int        nw;
        int        left;
        bit [3:0]  w;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every outcome, LRU eviction order, address extremes
        program_cache(5'd4, 5'd2, 5'd2);
        for (k = 0; k < 14; k++)
            send_address(directed_addr[k]);
        i_in_valid <= 1'b0;
        drain_lookups();

        // random phases: a small working set per phase so hits and evictions recur
        for (p = 0; p < N_PHASES; p++) begin
            program_cache(phase_off[p], phase_idx[p], phase_ways[p]);
            w = phase_ways[p][3:0];
            nw = (w == 0) ? 1 : (w > 8) ? 8 : w;
            tag_pool.delete();
            set_pool.delete();
            for (k = 0; k < nw + 2; k++)
                tag_pool.push_back($urandom);
            for (k = 0; k < $urandom_range(1, 3); k++)
                set_pool.push_back($urandom);
            no_idle = (p % 5 == 4);
            if (p == 2)
                hold_cycles = 300;
            for (k = 0; k < PHASE_LEN; k++) begin
                if ($urandom_range(0, 99) < 15)
                    send_address($urandom);
                else
                    send_address(form_address(
                        tag_pool[$urandom_range(0, tag_pool.size() - 1)],
                        set_pool[$urandom_range(0, set_pool.size() - 1)],
                        phase_off[p], phase_idx[p][3:0]));
            end
            i_in_valid <= 1'b0;
            no_idle = 1'b0;
            drain_lookups();
        end

        // final wait, bounded; anything still outstanding is a failure
        left = 0;
        while (sb.pending_lookups.size() != 0 && left < 5000) begin
            @(posedge i_clk);
            left++;
        end
        if (sb.pending_lookups.size() != 0) begin
            $display("%0d results never arrived", sb.pending_lookups.size());
            sb.errors += sb.pending_lookups.size();
        end
        repeat (20) @(posedge i_clk);

        $display("Checked %0d lookups over %0d register settings, %0d failures",
                 sb.checked, N_PHASES + 1, sb.errors);
        $display("Outcomes seen: %0d hits, %0d compulsory misses, %0d capacity misses",
                 sb.outcome_count[0], sb.outcome_count[1], sb.outcome_count[2]);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
rtl/core/salc_pkg.sv
rtl/core/salc_ram.sv
rtl/core/salc_addr_split.sv
rtl/core/salc_lru_update.sv
rtl/core/set_assoc_lru_cache_lookup.sv
test/set_assoc_lru_cache_lookup_tb.sv
